[sv/sha224_hash_engine_unit_defines.svh]
// Assertion macros shared by the SHA-224 engine.
`ifndef SHA224_HASH_ENGINE_UNIT_DEFINES_SVH
`define SHA224_HASH_ENGINE_UNIT_DEFINES_SVH
// Property that holds whenever reset is released.
`define SHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property that must also hold during reset.
`define SHA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[sv/sha224_pkg.sv]
// ----------------------------------------------------------------------------
// sha224_pkg
// Types, constants and round functions for the SHA-224 engine.
// ----------------------------------------------------------------------------
package sha224_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 61;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic load;    // copy chain into working vars
    logic step;    // run one round
    logic update;  // add working vars into chain
    logic init;    // reload initial values
  } rnd_ctrl_t;

  localparam word_t PAD_WORD = 32'h8000_0000;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0: v = 32'hc1059ed8;
      3'd1: v = 32'h367cd507;
      3'd2: v = 32'h3070dd17;
      3'd3: v = 32'hf70e5939;
      3'd4: v = 32'hffc00b31;
      3'd5: v = 32'h68581511;
      3'd6: v = 32'h64f98fa7;
      default: v = 32'hbefa4fa4;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[idx];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

endpackage

[sv/sha224_sched.sv]
// ----------------------------------------------------------------------------
// sha224_sched
// Sixteen-word block buffer and message schedule as a shift window.
// ----------------------------------------------------------------------------
module sha224_sched (
  input  logic                clk,
  input  logic                wr_en,
  input  sha224_pkg::word_t   wr_data,
  input  logic                step,
  output sha224_pkg::word_t   w_out
);

  sha224_pkg::word_t win_r [16];
  sha224_pkg::word_t s0;
  sha224_pkg::word_t s1;
  sha224_pkg::word_t w_new;

  // Next schedule word from the window taps
  always_comb begin
    s0 = sha224_pkg::rotr(win_r[1], 7) ^ sha224_pkg::rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1 = sha224_pkg::rotr(win_r[14], 17) ^ sha224_pkg::rotr(win_r[14], 19)
       ^ (win_r[14] >> 10);
    w_new = s1 + win_r[9] + s0 + win_r[0];
  end

  assign w_out = win_r[0];

  // Shift in message words on write, schedule words on each round
  always_ff @(posedge clk) begin
    if (wr_en || step) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= wr_en ? wr_data : w_new;
    end
  end

endmodule

[sv/sha224_round.sv]
// ----------------------------------------------------------------------------
// sha224_round
// Chaining state, working variables and the shared one-round datapath.
// ----------------------------------------------------------------------------
module sha224_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha224_pkg::rnd_ctrl_t ctrl,
  input  logic [5:0]            rnd_idx,
  input  sha224_pkg::word_t     w_in,
  input  logic [2:0]            rd_idx,
  output sha224_pkg::word_t     rd_data
);

  sha224_pkg::word_t h_r [8];
  sha224_pkg::word_t v_r [8];
  sha224_pkg::word_t t1;
  sha224_pkg::word_t t2;

  // One compression round
  always_comb begin
    t1 = v_r[7] + (sha224_pkg::rotr(v_r[4], 6) ^ sha224_pkg::rotr(v_r[4], 11)
       ^ sha224_pkg::rotr(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + sha224_pkg::round_k(rnd_idx) + w_in;
    t2 = (sha224_pkg::rotr(v_r[0], 2) ^ sha224_pkg::rotr(v_r[0], 13)
       ^ sha224_pkg::rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  assign rd_data = h_r[rd_idx];

  // Hold chain and working state
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha224_pkg::init_hash(3'(i));
        v_r[i] <= '0;
      end
    end else if (ctrl.load) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (ctrl.step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (ctrl.update) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

endmodule

[sv/sha224_hash_engine_unit.sv]
// ----------------------------------------------------------------------------
// sha224_hash_engine_unit
// SHA-224 engine: word packing, padding and iterative compression.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one big-endian message word, its byte count and a
//   last flag. A word that fills a 16-word block starts a compression of 64
//   rounds at one round a cycle on the shared round unit, followed by an
//   update step that folds into the chain; in_stall is high meanwhile. Other
//   words are accepted without a stall.
//   On a last request the engine writes the pad and length one word a cycle,
//   compressing once or twice, then sends seven digest words on the result
//   channel, index 0 first, digest_last on the seventh. A stalled result
//   holds until taken; no input is accepted until all seven are gone. The
//   engine then returns to the initial values.
//   Reset clears the chain to the initial values, the counters to zero and
//   drops any result in flight.
// ----------------------------------------------------------------------------
`include "sha224_hash_engine_unit_defines.svh"
module sha224_hash_engine_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               in_message_word,
  input  logic [2:0]                in_byte_count,
  input  logic                      in_is_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               out_digest_word,
  output logic [2:0]                out_word_index,
  output logic                      out_digest_last
);

  sha224_pkg::state_t state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [60:0] len_r, len_nxt;
  logic        pad_r, pad_nxt;     // a separate pad word (0x80 word) still due
  logic        fin_r, fin_nxt;     // last word taken; padding or digest in progress
  logic        spill_r, spill_nxt; // pad landed in the last two words; length goes in next block
  logic [2:0]  oidx_r, oidx_nxt;

  logic                  acc;
  logic [2:0]            nb;
  logic                  wr_en;
  sha224_pkg::word_t     wr_data;
  sha224_pkg::word_t     w_cur;
  sha224_pkg::word_t     pad_word;
  sha224_pkg::word_t     keep;
  sha224_pkg::rnd_ctrl_t ctrl;
  logic [63:0]           bits;
  logic                  out_take;

  assign acc      = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign nb       = (!in_is_last || in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
  assign bits     = {len_r, 3'b000};

  // Mask partial word and place the pad byte
  always_comb begin
    case (nb)
      3'd1: keep = 32'hff00_0000;
      3'd2: keep = 32'hffff_0000;
      3'd3: keep = 32'hffff_ff00;
      default: keep = '0;
    endcase
    pad_word = (in_message_word & keep) | (sha224_pkg::PAD_WORD >> {nb, 3'b000});
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    rnd_nxt   = rnd_r;
    len_nxt   = len_r;
    pad_nxt   = pad_r;
    fin_nxt   = fin_r;
    spill_nxt = spill_r;
    oidx_nxt  = oidx_r;
    case (state_r)
      sha224_pkg::ST_IDLE: begin
        if (acc) begin
          len_nxt = len_r + 61'(nb);
          pos_nxt = pos_r + 4'd1;
          if (in_is_last) begin
            fin_nxt   = 1'b1;
            pad_nxt   = (nb == 3'd4);
            spill_nxt = (nb != 3'd4) && (pos_r >= 4'd14);
          end
          if (pos_r == 4'd15) begin
            state_nxt = sha224_pkg::ST_ROUND;
          end else if (in_is_last) begin
            state_nxt = sha224_pkg::ST_PAD;
          end
        end
      end
      sha224_pkg::ST_PAD: begin
        pad_nxt = 1'b0;
        pos_nxt = pos_r + 4'd1;
        if (pad_r && pos_r >= 4'd14) begin
          spill_nxt = 1'b1;
        end
        if (pos_r == 4'd15) begin
          state_nxt = sha224_pkg::ST_ROUND;
        end
      end
      sha224_pkg::ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = sha224_pkg::ST_UPDATE;
        end
      end
      sha224_pkg::ST_UPDATE: begin
        if (!fin_r) begin
          state_nxt = sha224_pkg::ST_IDLE;
        end else if (pad_r || spill_r) begin
          // pad word or length still due: fill one more block
          spill_nxt = 1'b0;
          state_nxt = sha224_pkg::ST_PAD;
        end else begin
          state_nxt = sha224_pkg::ST_EMIT;
        end
      end
      sha224_pkg::ST_EMIT: begin
        if (out_take) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd6) begin
            state_nxt = sha224_pkg::ST_IDLE;
            oidx_nxt  = '0;
            fin_nxt   = 1'b0;
            len_nxt   = '0;
            pos_nxt   = '0;
          end
        end
      end
      default: state_nxt = sha224_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    ctrl     = '0;
    wr_en    = 1'b0;
    wr_data  = '0;
    in_stall = (state_r != sha224_pkg::ST_IDLE);
    out_valid = (state_r == sha224_pkg::ST_EMIT);
    case (state_r)
      sha224_pkg::ST_IDLE: begin
        wr_en   = acc;
        wr_data = (in_is_last && nb != 3'd4) ? pad_word : in_message_word;
        ctrl.load = acc && (pos_r == 4'd15);
      end
      sha224_pkg::ST_PAD: begin
        wr_en = 1'b1;
        if (pad_r) begin
          wr_data = sha224_pkg::PAD_WORD;
        end else if (spill_r) begin
          wr_data = '0;
        end else if (pos_r == 4'd14) begin
          wr_data = bits[63:32];
        end else if (pos_r == 4'd15) begin
          wr_data = bits[31:0];
        end else begin
          wr_data = '0;
        end
        ctrl.load = (pos_r == 4'd15);
      end
      sha224_pkg::ST_ROUND: ctrl.step = 1'b1;
      sha224_pkg::ST_UPDATE: ctrl.update = 1'b1;
      sha224_pkg::ST_EMIT: ctrl.init = out_take && (oidx_r == 3'd6);
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha224_pkg::ST_IDLE;
      pos_r   <= '0;
      rnd_r   <= '0;
      len_r   <= '0;
      pad_r   <= 1'b0;
      fin_r   <= 1'b0;
      spill_r <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      len_r   <= len_nxt;
      pad_r   <= pad_nxt;
      fin_r   <= fin_nxt;
      spill_r <= spill_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  sha224_sched u_sched (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .step    (ctrl.step),
    .w_out   (w_cur)
  );

  sha224_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rnd_idx (rnd_r),
    .w_in    (w_cur),
    .rd_idx  (oidx_r),
    .rd_data (out_digest_word)
  );

  assign out_word_index  = oidx_r;
  assign out_digest_last = (oidx_r == 3'd6);

  // Checks
  `SHA_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "digest valid right after reset")
  `SHA_ASSERT(a_excl, !(out_valid && !in_stall), "input open while digest pending")
  `SHA_ASSERT(a_rnd_idle, (state_r != sha224_pkg::ST_ROUND) |-> (rnd_r == 6'd0), "round count not zero between blocks")
  `SHA_ASSERT(a_blk_full, ctrl.load |-> (pos_nxt == 4'd0), "compression started on partial block")

endmodule
